@@ hw/rtl/bpa_pkg.sv @@
// Package for the buddy page allocator: request and response payload types,
// operation, status and register index codes, and default sizing constants.
// No dependencies.
package bpa_pkg;

  localparam int DEF_ZONES      = 4;
  localparam int DEF_FRAMES     = 4096;
  localparam int DEF_HIGH_ORDER = 10;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_MIGRATE = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_BADARG = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONES_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE0_PAGES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE1_PAGES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE2_PAGES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE3_PAGES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG       = 3'd5;

  localparam logic [2:0]            RST_ZONES_IN_USE = 3'd1;
  localparam logic [CFG_DATA_W-1:0] RST_ZONE0_PAGES  = 13'd4096;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  block_order;
    logic [1:0]  node;
    logic [1:0]  target_node;
    logic        strict_node;
    logic [11:0] page_frame;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  result_node;
    logic [11:0] result_frame;
    logic [12:0] zone_free_pages;
    logic [14:0] total_free_pages;
  } rsp_t;

endpackage

@@ hw/rtl/buddy_page_allocator.sv @@
// Buddy page allocator top level: sequencer, per-frame record memory and
// free-list head memory. Depends on bpa_pkg.
//
// Usage. Requests enter on in_valid/in_req and are accepted when in_stall is
// low; one request is worked at a time and in_stall stays high until its
// response is built. Each request yields exactly one response on
// out_valid/out_rsp, held in an output register until out_stall is low, so a
// new request may be accepted while the previous response still waits.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high. A write to a defined register rebuilds every zone.
// Work per request is set by the single-port sequencing of the frame record
// memory (one read or one write per cycle): allocate scans the orders,
// unlinks the head, splits level by level, then marks each page; free
// checks and clears each page, merges level by level and ends with the
// final insert. Reset and every rebuild run a clearing pass that writes
// every frame record and list head; no request is accepted during the pass.
// When out_stall is held high a finished response waits in the output
// register and further work stops only once the next response is ready to
// be written.
module buddy_page_allocator #(
  parameter int ZONES      = bpa_pkg::DEF_ZONES,
  parameter int FRAMES     = bpa_pkg::DEF_FRAMES,
  parameter int HIGH_ORDER = bpa_pkg::DEF_HIGH_ORDER
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpa_pkg::req_t                  in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpa_pkg::rsp_t                  out_rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpa_pkg::*;

  localparam int FW   = $clog2(FRAMES);
  localparam int OW   = $clog2(HIGH_ORDER + 1);
  localparam int ZW   = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int ZUW  = $clog2(ZONES + 1);
  localparam int CW   = $clog2(FRAMES + 1);
  localparam int W0   = (FW > HIGH_ORDER + 1) ? FW : HIGH_ORDER + 1;
  localparam int WW   = ((W0 > 12) ? W0 : 12) + 1;
  localparam int TW   = CW + ZW;
  localparam int CA   = ZW + FW;
  localparam int HA   = ZW + OW;
  localparam int CDEPTH = ZONES << FW;
  localparam int HDEPTH = ZONES << OW;
  localparam logic [WW-1:0] TOP  = WW'(1) << HIGH_ORDER;
  localparam logic [WW-1:0] TOPM = TOP - WW'(1);
  localparam logic [OW-1:0] MAXO = OW'(HIGH_ORDER);

  // One record per frame: allocation bit plus free-list membership.
  typedef struct packed {
    logic          alloc;
    logic          head_ok;
    logic [OW-1:0] ord;
    logic          fwd_ok;
    logic [FW-1:0] fwd;
    logic          bwd_ok;
    logic [FW-1:0] bwd;
  } cell_t;

  typedef struct packed {
    logic          full;
    logic [FW-1:0] head;
  } head_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_FV_CHK, S_FV_RD, S_FV_CK, S_MK_RD, S_MK_WR,
    S_FR_CNT, S_MG_TEST, S_MG_RD, S_MG_CK, S_FR_END, S_AL_START, S_TK_RD,
    S_TK_CK, S_TK_CELL, S_SPLIT, S_TK_END, S_RM_W0, S_RM_PRD, S_RM_PWR,
    S_RM_NRD, S_RM_NWR, S_PU_HRD, S_PU_CRD, S_PU_CWR, S_PU_PRD, S_PU_PWR,
    S_PU_HWR, S_DONE
  } state_t;

  // Configuration registers.
  logic [2:0]            cfg_zones_r;
  logic [CFG_DATA_W-1:0] pg_r [4];

  // Sequencer state.
  state_t              state_r;
  state_t              ret_r;
  logic [CA-1:0]       sw_r;
  req_t                req_r;
  logic [ZW-1:0]       rz_r;
  logic [1:0]          nd_r;
  logic                strict_r;
  logic [ZUW-1:0]      try_r;
  logic [OW-1:0]       ord_r;
  logic [OW-1:0]       ro_r;
  logic [OW-1:0]       lo_r;
  logic [FW-1:0]       rf_r;
  logic [FW-1:0]       la_r;
  logic [HIGH_ORDER-1:0] cnt_r;
  logic                mk_val_r;
  cell_t               rec_r;
  head_t               hd_r;
  logic [1:0]          st_r;
  logic [ZW-1:0]       res_z_r;
  logic [FW-1:0]       res_f_r;
  logic [CW-1:0]       zcnt_r [ZONES];
  logic                out_valid_r;
  rsp_t                out_rsp_r;

  // Memories.
  cell_t cmem [CDEPTH];
  head_t hmem [HDEPTH];
  cell_t cm_q, cm_wdata;
  head_t hm_q, hm_wdata;
  logic  cm_re, cm_we, hm_re, hm_we;
  logic [CA-1:0] cm_raddr, cm_waddr;
  logic [HA-1:0] hm_raddr, hm_waddr;

  function automatic logic [WW-1:0] pages_of(input logic [ZW-1:0] z);
    logic [WW-1:0] p;
    p = '0;
    for (int i = 0; i < 4; i++) begin
      if (int'(z) == i) p = WW'(pg_r[i]);
    end
    if (p > WW'(FRAMES)) p = WW'(FRAMES);
    return p;
  endfunction

  function automatic logic [ZW-1:0] zmod(input logic [1:0] n, input logic [ZUW-1:0] m);
    int v;
    v = int'(n);
    for (int i = 0; i < 3; i++) begin
      if (v >= int'(m)) v = v - int'(m);
    end
    return ZW'(v);
  endfunction

  // Effective zone count and derived values.
  logic [ZUW-1:0] zu;
  logic [WW-1:0]  rz_pg, size_w, bit_w, mg_b, sp_half, pfe;
  logic           cnt_last, mg_ok, fv_bad;
  logic [FW-1:0]  mk_f;
  logic [TW-1:0]  tot;
  logic           cfg_rebuild, out_fire;

  // A defined register write takes priority over any sequencer step.
  assign cfg_rebuild = cfg_valid && (cfg_index <= CFG_ZONE3_PAGES);
  assign out_fire    = (state_r == S_DONE) && !cfg_rebuild && (!out_valid_r || !out_stall);

  always_comb begin
    if (cfg_zones_r == '0) zu = ZUW'(1);
    else if (int'(cfg_zones_r) > ZONES) zu = ZUW'(ZONES);
    else zu = ZUW'(cfg_zones_r);
    rz_pg    = pages_of(rz_r);
    size_w   = WW'(1) << ord_r;
    bit_w    = WW'(1) << ro_r;
    mg_b     = WW'(rf_r) ^ bit_w;
    mg_ok    = (ro_r < MAXO) && ((mg_b + bit_w) <= rz_pg);
    sp_half  = WW'(1) << (ro_r - OW'(1));
    cnt_last = (WW'(cnt_r) == (size_w - WW'(1)));
    mk_f     = FW'(WW'(rf_r) + WW'(cnt_r));
    pfe      = WW'(req_r.page_frame);
    fv_bad   = (pfe >= rz_pg) || ((pfe & (size_w - WW'(1))) != '0) ||
               ((pfe + size_w) > rz_pg);
    tot = '0;
    for (int z = 0; z < ZONES; z++) begin
      if (z < int'(zu)) tot = tot + TW'(zcnt_r[z]);
    end
  end

  // Contents written by the clearing pass: maximum-order blocks first, then
  // leftover single pages, each list linked with its highest frame at the head.
  logic [ZW-1:0] swz, hz;
  logic [FW-1:0] swf;
  logic [OW-1:0] ho;
  logic [WW-1:0] sw_pg, sw_mend, fe, h_pg, h_mend;
  logic          is_max, is_lo;
  cell_t         init_cell;
  head_t         init_head;

  always_comb begin
    swz     = sw_r[CA-1:FW];
    swf     = sw_r[FW-1:0];
    sw_pg   = pages_of(swz);
    sw_mend = sw_pg & ~TOPM;
    fe      = WW'(swf);
    is_max  = (fe < sw_mend) && ((fe & TOPM) == '0);
    is_lo   = (fe < sw_pg) && !(fe < sw_mend);
    init_cell = '0;
    if (is_max) begin
      init_cell.head_ok = 1'b1;
      init_cell.ord     = MAXO;
      init_cell.fwd_ok  = (fe >= TOP);
      init_cell.fwd     = FW'(fe - TOP);
      init_cell.bwd_ok  = ((fe + TOP) < sw_mend);
      init_cell.bwd     = FW'(fe + TOP);
    end else if (is_lo) begin
      init_cell.head_ok = 1'b1;
      init_cell.fwd_ok  = (fe > sw_mend);
      init_cell.fwd     = FW'(fe - WW'(1));
      init_cell.bwd_ok  = ((fe + WW'(1)) < sw_pg);
      init_cell.bwd     = FW'(fe + WW'(1));
    end
    hz     = sw_r[HA-1:OW];
    ho     = sw_r[OW-1:0];
    h_pg   = pages_of(hz);
    h_mend = h_pg & ~TOPM;
    init_head = '0;
    if (ho == MAXO) begin
      init_head.full = (h_mend != '0);
      init_head.head = FW'(h_mend - TOP);
    end else if (ho == '0) begin
      init_head.full = (h_pg > h_mend);
      init_head.head = FW'(h_pg - WW'(1));
    end
  end

  // Memory port control per sequencer step.
  always_comb begin
    cm_re    = 1'b0;
    cm_raddr = {rz_r, la_r};
    cm_we    = 1'b0;
    cm_waddr = {rz_r, la_r};
    cm_wdata = cm_q;
    hm_re    = 1'b0;
    hm_raddr = {rz_r, lo_r};
    hm_we    = 1'b0;
    hm_waddr = {rz_r, lo_r};
    hm_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = sw_r;
        cm_wdata = init_cell;
        hm_we    = (int'(sw_r) < HDEPTH);
        hm_waddr = sw_r[HA-1:0];
        hm_wdata = init_head;
      end
      S_FV_RD, S_MK_RD: begin
        cm_re    = 1'b1;
        cm_raddr = {rz_r, mk_f};
      end
      S_MK_WR: begin
        cm_we          = 1'b1;
        cm_waddr       = {rz_r, mk_f};
        cm_wdata.alloc = mk_val_r;
      end
      S_MG_RD, S_PU_CRD: begin
        cm_re = 1'b1;
      end
      S_TK_RD: begin
        hm_re    = 1'b1;
        hm_raddr = {rz_r, ro_r};
      end
      S_TK_CK: begin
        cm_re    = hm_q.full;
        cm_raddr = {rz_r, hm_q.head};
      end
      S_RM_W0: begin
        cm_we           = 1'b1;
        cm_wdata        = rec_r;
        cm_wdata.head_ok = 1'b0;
        cm_wdata.fwd_ok = 1'b0;
        cm_wdata.bwd_ok = 1'b0;
        hm_we           = !rec_r.bwd_ok;
        hm_wdata        = '{full: rec_r.fwd_ok, head: rec_r.fwd};
      end
      S_RM_PRD: begin
        cm_re    = 1'b1;
        cm_raddr = {rz_r, rec_r.bwd};
      end
      S_RM_PWR: begin
        cm_we           = 1'b1;
        cm_waddr        = {rz_r, rec_r.bwd};
        cm_wdata.fwd    = rec_r.fwd;
        cm_wdata.fwd_ok = rec_r.fwd_ok;
      end
      S_RM_NRD: begin
        cm_re    = 1'b1;
        cm_raddr = {rz_r, rec_r.fwd};
      end
      S_RM_NWR: begin
        cm_we           = 1'b1;
        cm_waddr        = {rz_r, rec_r.fwd};
        cm_wdata.bwd    = rec_r.bwd;
        cm_wdata.bwd_ok = rec_r.bwd_ok;
      end
      S_PU_HRD: begin
        hm_re = 1'b1;
      end
      S_PU_CWR: begin
        cm_we            = 1'b1;
        cm_wdata.head_ok = 1'b1;
        cm_wdata.ord     = lo_r;
        cm_wdata.fwd_ok  = hd_r.full;
        cm_wdata.fwd     = hd_r.head;
        cm_wdata.bwd_ok  = 1'b0;
        cm_wdata.bwd     = '0;
      end
      S_PU_PRD: begin
        cm_re    = 1'b1;
        cm_raddr = {rz_r, hd_r.head};
      end
      S_PU_PWR: begin
        cm_we           = 1'b1;
        cm_waddr        = {rz_r, hd_r.head};
        cm_wdata.bwd    = la_r;
        cm_wdata.bwd_ok = 1'b1;
      end
      S_PU_HWR: begin
        hm_we    = 1'b1;
        hm_wdata = '{full: 1'b1, head: la_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_q <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (hm_we) hmem[hm_waddr] <= hm_wdata;
    if (hm_re) hm_q <= hmem[hm_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sw_r        <= '0;
      cfg_zones_r <= RST_ZONES_IN_USE;
      pg_r[0]     <= RST_ZONE0_PAGES;
      pg_r[1]     <= '0;
      pg_r[2]     <= '0;
      pg_r[3]     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      // A write to a defined register rebuilds all zones from scratch.
      if (cfg_rebuild) begin
        state_r <= S_CLR;
        sw_r    <= '0;
      end else begin
        unique case (state_r)
          S_CLR: begin
            if (sw_r == '0) begin
              for (int z = 0; z < ZONES; z++) zcnt_r[z] <= CW'(pages_of(ZW'(z)));
            end
            if (sw_r == CA'(CDEPTH - 1)) state_r <= S_IDLE;
            else sw_r <= sw_r + CA'(1);
          end
          S_IDLE: begin
            if (in_valid) begin
              req_r   <= in_req;
              state_r <= S_DEC;
            end
          end
          S_DEC: begin
            st_r    <= ST_BADARG;
            res_z_r <= '0;
            res_f_r <= '0;
            nd_r     <= req_r.node;
            strict_r <= req_r.strict_node;
            rz_r     <= ZW'(req_r.node);
            // A migrate always moves a single page.
            ord_r    <= (req_r.kind == KIND_MIGRATE) ? '0 : OW'(req_r.block_order);
            if (req_r.kind == KIND_ALLOC && int'(req_r.block_order) <= HIGH_ORDER) begin
              state_r <= S_AL_START;
            end else if (req_r.kind == KIND_FREE &&
                         int'(req_r.block_order) <= HIGH_ORDER &&
                         int'(req_r.node) < int'(zu)) begin
              state_r <= S_FV_CHK;
            end else if (req_r.kind == KIND_MIGRATE && int'(req_r.node) < int'(zu)) begin
              state_r <= S_FV_CHK;
            end else begin
              state_r <= S_DONE;
            end
          end
          S_FV_CHK: begin
            rf_r  <= FW'(req_r.page_frame);
            cnt_r <= '0;
            state_r <= fv_bad ? S_DONE : S_FV_RD;
          end
          S_FV_RD: state_r <= S_FV_CK;
          S_FV_CK: begin
            if (!cm_q.alloc) begin
              state_r <= S_DONE;
            end else if (cnt_last) begin
              cnt_r    <= '0;
              mk_val_r <= 1'b0;
              ret_r    <= S_FR_CNT;
              state_r  <= S_MK_RD;
            end else begin
              cnt_r   <= cnt_r + HIGH_ORDER'(1);
              state_r <= S_FV_RD;
            end
          end
          S_MK_RD: state_r <= S_MK_WR;
          S_MK_WR: begin
            if (cnt_last) begin
              state_r <= ret_r;
            end else begin
              cnt_r   <= cnt_r + HIGH_ORDER'(1);
              state_r <= S_MK_RD;
            end
          end
          S_FR_CNT: begin
            zcnt_r[rz_r] <= CW'(WW'(zcnt_r[rz_r]) + size_w);
            ro_r    <= ord_r;
            state_r <= S_MG_TEST;
          end
          S_MG_TEST: begin
            if (mg_ok) begin
              la_r    <= FW'(mg_b);
              state_r <= S_MG_RD;
            end else begin
              lo_r    <= ro_r;
              la_r    <= rf_r;
              ret_r   <= S_FR_END;
              state_r <= S_PU_HRD;
            end
          end
          S_MG_RD: state_r <= S_MG_CK;
          S_MG_CK: begin
            // The buddy merges only when it heads a free block of this order.
            if (cm_q.head_ok && cm_q.ord == ro_r) begin
              rec_r   <= cm_q;
              lo_r    <= ro_r;
              rf_r    <= rf_r & la_r;
              ro_r    <= ro_r + OW'(1);
              ret_r   <= S_MG_TEST;
              state_r <= S_RM_W0;
            end else begin
              lo_r    <= ro_r;
              la_r    <= rf_r;
              ret_r   <= S_FR_END;
              state_r <= S_PU_HRD;
            end
          end
          S_FR_END: begin
            st_r <= ST_OK;
            if (req_r.kind == KIND_MIGRATE) begin
              nd_r     <= req_r.target_node;
              strict_r <= 1'b1;
              ord_r    <= '0;
              state_r  <= S_AL_START;
            end else begin
              state_r <= S_DONE;
            end
          end
          S_AL_START: begin
            st_r    <= ST_NOMEM;
            rz_r    <= zmod(nd_r, zu);
            try_r   <= '0;
            ro_r    <= ord_r;
            state_r <= S_TK_RD;
          end
          S_TK_RD: state_r <= S_TK_CK;
          S_TK_CK: begin
            if (hm_q.full) begin
              rf_r    <= hm_q.head;
              state_r <= S_TK_CELL;
            end else if (ro_r == MAXO) begin
              if (!strict_r && (int'(try_r) + 1 < int'(zu))) begin
                try_r   <= try_r + ZUW'(1);
                rz_r    <= (int'(rz_r) + 1 == int'(zu)) ? '0 : rz_r + ZW'(1);
                ro_r    <= ord_r;
                state_r <= S_TK_RD;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              ro_r    <= ro_r + OW'(1);
              state_r <= S_TK_RD;
            end
          end
          S_TK_CELL: begin
            rec_r   <= cm_q;
            lo_r    <= ro_r;
            la_r    <= rf_r;
            ret_r   <= S_SPLIT;
            state_r <= S_RM_W0;
          end
          S_SPLIT: begin
            // Push the upper half at each level and keep the lower half.
            if (ro_r > ord_r) begin
              ro_r    <= ro_r - OW'(1);
              lo_r    <= ro_r - OW'(1);
              la_r    <= FW'(WW'(rf_r) + sp_half);
              ret_r   <= S_SPLIT;
              state_r <= S_PU_HRD;
            end else begin
              cnt_r    <= '0;
              mk_val_r <= 1'b1;
              ret_r    <= S_TK_END;
              state_r  <= S_MK_RD;
            end
          end
          S_TK_END: begin
            zcnt_r[rz_r] <= CW'(WW'(zcnt_r[rz_r]) - size_w);
            st_r    <= ST_OK;
            res_z_r <= rz_r;
            res_f_r <= rf_r;
            state_r <= S_DONE;
          end
          S_RM_W0: begin
            if (rec_r.bwd_ok) state_r <= S_RM_PRD;
            else if (rec_r.fwd_ok) state_r <= S_RM_NRD;
            else state_r <= ret_r;
          end
          S_RM_PRD: state_r <= S_RM_PWR;
          S_RM_PWR: state_r <= rec_r.fwd_ok ? S_RM_NRD : ret_r;
          S_RM_NRD: state_r <= S_RM_NWR;
          S_RM_NWR: state_r <= ret_r;
          S_PU_HRD: state_r <= S_PU_CRD;
          S_PU_CRD: begin
            hd_r    <= hm_q;
            state_r <= S_PU_CWR;
          end
          S_PU_CWR: state_r <= hd_r.full ? S_PU_PRD : S_PU_HWR;
          S_PU_PRD: state_r <= S_PU_PWR;
          S_PU_PWR: state_r <= S_PU_HWR;
          S_PU_HWR: state_r <= ret_r;
          S_DONE: begin
            if (out_fire) begin
              out_rsp_r.status           <= st_r;
              out_rsp_r.result_node      <= 2'(res_z_r);
              out_rsp_r.result_frame     <= 12'(res_f_r);
              out_rsp_r.zone_free_pages  <= (st_r == ST_BADARG) ? '0 : 13'(zcnt_r[rz_r]);
              out_rsp_r.total_free_pages <= 15'(tot);
              state_r                    <= S_IDLE;
            end
          end
          default: ;
        endcase
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ZONES_IN_USE: cfg_zones_r <= cfg_data[2:0];
          CFG_ZONE0_PAGES:  pg_r[0] <= cfg_data;
          CFG_ZONE1_PAGES:  pg_r[1] <= cfg_data;
          CFG_ZONE2_PAGES:  pg_r[2] <= cfg_data;
          CFG_ZONE3_PAGES:  pg_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE) || cfg_rebuild;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;

  // The sequencer never reads a frame record in the cycle it writes it.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cm_we && cm_re && cm_waddr == cm_raddr))
    else $error("frame record read and written in the same cycle");

  // A block pushed onto a list is never already that list's head.
  a_push_not_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PU_CWR) |-> !(hd_r.full && hd_r.head == la_r))
    else $error("free list push would link a block to itself");

  // A successful take always finds enough free pages in the zone count.
  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TK_END) |-> (WW'(zcnt_r[rz_r]) >= size_w))
    else $error("zone free count below allocated block size");

  // A defined register write always restarts the rebuild pass.
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index <= CFG_ZONE3_PAGES) |=> (state_r == S_CLR && sw_r == '0))
    else $error("configuration write did not restart the rebuild");

  // A response is only presented after the sequencer finished a request.
  a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("response appeared without a finished request");

endmodule

@@ verif/bpa_checker.sv @@
// Checker for the buddy page allocator: watches the request, response and
// configuration channels, keeps its own allocator state and compares every
// response. Depends on bpa_pkg.
`timescale 1ns / 100ps
module bpa_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  bpa_pkg::req_t                  in_req,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  bpa_pkg::rsp_t                  out_rsp,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             waiting_count
);
  import bpa_pkg::*;

  localparam int NZ = 4;
  localparam int NF = 4096;
  localparam int TOP = 10;
  localparam int NORD = TOP + 1;

  logic [2:0]  zones_reg;
  logic [12:0] zone_pages_reg [NZ];

  bit          page_used [NZ*NF];
  bit          head_valid [NZ*NF];
  logic [3:0]  head_order [NZ*NF];
  int          fwd [NZ*NF];
  bit          fwd_valid [NZ*NF];
  int          back [NZ*NF];
  bit          back_valid [NZ*NF];
  int          first_free [NZ*NORD];
  bit          list_busy [NZ*NORD];
  int          zone_free [NZ];

  rsp_t awaited_rsp [$];

  function automatic int zones_active();
    if (zones_reg == 0) return 1;
    if (int'(zones_reg) > NZ) return NZ;
    return int'(zones_reg);
  endfunction

  function automatic int zone_size(int z);
    return (int'(zone_pages_reg[z]) > NF) ? NF : int'(zone_pages_reg[z]);
  endfunction

  function automatic void link_in(int z, int o, int f);
    int l, c;
    l = z * NORD + o;
    c = z * NF + f;
    fwd_valid[c] = list_busy[l];
    fwd[c] = first_free[l];
    back_valid[c] = 0;
    back[c] = 0;
    if (list_busy[l]) begin
      back[z * NF + first_free[l]] = f;
      back_valid[z * NF + first_free[l]] = 1;
    end
    first_free[l] = f;
    list_busy[l] = 1;
    head_valid[c] = 1;
    head_order[c] = 4'(o);
  endfunction

  function automatic void unlink(int z, int o, int f);
    int l, c;
    l = z * NORD + o;
    c = z * NF + f;
    if (back_valid[c]) begin
      fwd[z * NF + back[c]] = fwd[c];
      fwd_valid[z * NF + back[c]] = fwd_valid[c];
    end else begin
      first_free[l] = fwd[c];
      list_busy[l] = fwd_valid[c];
    end
    if (fwd_valid[c]) begin
      back[z * NF + fwd[c]] = back[c];
      back_valid[z * NF + fwd[c]] = back_valid[c];
    end
    head_valid[c] = 0;
    fwd_valid[c] = 0;
    back_valid[c] = 0;
  endfunction

  // Every zone restarts fully free: top-order blocks first, then single pages.
  function automatic void rebuild_zones();
    int f, pages;
    for (int i = 0; i < NZ * NF; i++) begin
      page_used[i] = 0; head_valid[i] = 0; head_order[i] = 0;
      fwd[i] = 0; fwd_valid[i] = 0; back[i] = 0; back_valid[i] = 0;
    end
    for (int i = 0; i < NZ * NORD; i++) begin
      first_free[i] = 0;
      list_busy[i] = 0;
    end
    for (int z = 0; z < NZ; z++) begin
      pages = zone_size(z);
      zone_free[z] = pages;
      f = 0;
      while (f + (1 << TOP) <= pages) begin
        link_in(z, TOP, f);
        f += 1 << TOP;
      end
      for (; f < pages; f++) link_in(z, 0, f);
    end
  endfunction

  function automatic bit carve_block(int z, int order, output int frame);
    int o, f;
    for (o = order; o <= TOP; o++)
      if (list_busy[z * NORD + o]) break;
    if (o > TOP) return 0;
    f = first_free[z * NORD + o];
    unlink(z, o, f);
    while (o > order) begin
      o--;
      link_in(z, o, f + (1 << o));
    end
    for (int i = 0; i < (1 << order); i++) page_used[z * NF + f + i] = 1;
    zone_free[z] -= 1 << order;
    frame = f;
    return 1;
  endfunction

  function automatic bit release_block(int z, int f, int order);
    int pages, size, o, b;
    pages = zone_size(z);
    size = 1 << order;
    if (f >= pages || (f & (size - 1)) != 0 || f + size > pages) return 0;
    for (int i = 0; i < size; i++)
      if (!page_used[z * NF + f + i]) return 0;
    for (int i = 0; i < size; i++) page_used[z * NF + f + i] = 0;
    zone_free[z] += size;
    o = order;
    while (o < TOP) begin
      b = f ^ (1 << o);
      if (b + (1 << o) > pages) break;
      if (!head_valid[z * NF + b] || int'(head_order[z * NF + b]) != o) break;
      unlink(z, o, b);
      f &= b;
      o++;
    end
    link_in(z, o, f);
    return 1;
  endfunction

  function automatic rsp_t buddy_outcome(req_t r);
    rsp_t res;
    int zu, ord, node, tries, z, f;
    bit strict, want_alloc;
    zu = zones_active();
    ord = int'(r.block_order);
    node = int'(r.node);
    strict = r.strict_node;
    want_alloc = 0;
    res = '0;
    res.status = ST_BADARG;
    if (r.kind == KIND_ALLOC && ord <= TOP) begin
      want_alloc = 1;
    end else if (r.kind == KIND_FREE && ord <= TOP && node < zu) begin
      if (release_block(node, int'(r.page_frame), ord)) begin
        res.status = ST_OK;
        res.zone_free_pages = 13'(zone_free[node]);
      end
    end else if (r.kind == KIND_MIGRATE && node < zu) begin
      if (release_block(node, int'(r.page_frame), 0)) begin
        want_alloc = 1;
        ord = 0;
        node = int'(r.target_node);
        strict = 1;
      end
    end
    if (want_alloc) begin
      tries = strict ? 1 : zu;
      res.status = ST_NOMEM;
      for (int t = 0; t < tries; t++) begin
        z = (node + t) % zu;
        res.zone_free_pages = 13'(zone_free[z]);
        if (carve_block(z, ord, f)) begin
          res.status = ST_OK;
          res.result_node = 2'(z);
          res.result_frame = 12'(f);
          res.zone_free_pages = 13'(zone_free[z]);
          break;
        end
      end
    end
    for (int i = 0; i < zu; i++) res.total_free_pages += 15'(zone_free[i]);
    return res;
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [12:0] val);
    case (idx)
      CFG_ZONES_IN_USE: zones_reg = val[2:0];
      CFG_ZONE0_PAGES:  zone_pages_reg[0] = val;
      CFG_ZONE1_PAGES:  zone_pages_reg[1] = val;
      CFG_ZONE2_PAGES:  zone_pages_reg[2] = val;
      CFG_ZONE3_PAGES:  zone_pages_reg[3] = val;
      default: return;
    endcase
    rebuild_zones();
  endfunction

  initial begin
    fail_count = 0;
    zones_reg = RST_ZONES_IN_USE;
    zone_pages_reg[0] = RST_ZONE0_PAGES;
    for (int z = 1; z < NZ; z++) zone_pages_reg[z] = '0;
    rebuild_zones();
  end

  assign waiting_count = awaited_rsp.size();

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response %p", $time, out_rsp);
          fail_count++;
        end else begin
          exp_rsp = awaited_rsp.pop_front();
          if (out_rsp.status !== exp_rsp.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_rsp.status, out_rsp.status);
            fail_count++;
          end
          if (out_rsp.result_node !== exp_rsp.result_node) begin
            $display("%0t: result_node exp %0d got %0d", $time,
                     exp_rsp.result_node, out_rsp.result_node);
            fail_count++;
          end
          if (out_rsp.result_frame !== exp_rsp.result_frame) begin
            $display("%0t: result_frame exp %0d got %0d", $time,
                     exp_rsp.result_frame, out_rsp.result_frame);
            fail_count++;
          end
          if (out_rsp.zone_free_pages !== exp_rsp.zone_free_pages) begin
            $display("%0t: zone_free_pages exp %0d got %0d", $time,
                     exp_rsp.zone_free_pages, out_rsp.zone_free_pages);
            fail_count++;
          end
          if (out_rsp.total_free_pages !== exp_rsp.total_free_pages) begin
            $display("%0t: total_free_pages exp %0d got %0d", $time,
                     exp_rsp.total_free_pages, out_rsp.total_free_pages);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) awaited_rsp.push_back(buddy_outcome(in_req));
    end
  end

endmodule

@@ verif/buddy_page_allocator_tb.sv @@
// Testbench top for the buddy page allocator: clock, reset, request and
// configuration stimulus, output stalls and the final verdict. Depends on
// bpa_pkg, buddy_page_allocator and bpa_checker.
`timescale 1ns / 100ps
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  // Generous ceiling: random orders are mostly small, but each rebuild runs
  // a full clearing pass and large frees walk a thousand pages.
  localparam int CYCLE_LIMIT = 12000000;
  localparam int REQ_W = $bits(req_t);

  typedef struct {
    logic [1:0]  zone;
    logic [11:0] frame;
    logic [3:0]  order;
  } block_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int waiting_count;

  // Blocks the block has handed out, used to build legal frees and migrates.
  block_t held_blocks [$];
  // Each request in flight, in order, so a successful response can be filed.
  req_t   in_flight [$];
  int     cycle_count;
  int     n_ok, n_nomem, n_badarg;
  bit     steady_out;

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bpa_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .waiting_count(waiting_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // The run is cut off if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Record each response: successful allocations and migrates add a block
  // to the pool that later frees draw from.
  always @(posedge clk) begin
    req_t r;
    if (rst_n && out_valid && !out_stall && in_flight.size() > 0) begin
      r = in_flight.pop_front();
      case (out_rsp.status)
        ST_OK:    n_ok++;
        ST_NOMEM: n_nomem++;
        default:  n_badarg++;
      endcase
      if (out_rsp.status == ST_OK && (r.kind == KIND_ALLOC || r.kind == KIND_MIGRATE))
        held_blocks.push_back('{out_rsp.result_node, out_rsp.result_frame,
                                (r.kind == KIND_MIGRATE) ? 4'd0 : r.block_order});
    end
  end

  // The receiver switches at random between stall patterns:
  // never stalling, random stalls, and a fixed duty pattern.
  initial begin
    int mode, phase;
    out_stall = 0;
    mode = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 200 == 0) mode = $urandom_range(0, 2);
      if (steady_out) out_stall <= 0;
      else if (mode == 0) out_stall <= 0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 99) < 35);
      else out_stall <= (phase % 7) < 4;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so a burst can continue without a dip.
  task automatic send_request(req_t r);
    in_req <= r;
    in_valid <= 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    in_flight.push_back(r);
    @(negedge clk);
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and hold until every response has come back.
  task automatic drain();
    idle_input(1);
    while (waiting_count != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Writes are made only with nothing in flight; the pool is then void.
  task automatic configure(int zones, int p0, int p1, int p2, int p3);
    drain();
    write_register(CFG_ZONES_IN_USE, CFG_DATA_W'(zones));
    write_register(CFG_ZONE0_PAGES, CFG_DATA_W'(p0));
    write_register(CFG_ZONE1_PAGES, CFG_DATA_W'(p1));
    write_register(CFG_ZONE2_PAGES, CFG_DATA_W'(p2));
    write_register(CFG_ZONE3_PAGES, CFG_DATA_W'(p3));
    held_blocks.delete();
  endtask

  function automatic logic [3:0] pick_order();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 4'd0;
    if (r < 85) return 4'($urandom_range(1, 3));
    if (r < 97) return 4'($urandom_range(4, 7));
    return 4'($urandom_range(8, 10));
  endfunction

  function automatic req_t make_alloc(logic [3:0] ord, logic [1:0] node, bit strict);
    req_t r;
    r = '0;
    r.kind = KIND_ALLOC;
    r.block_order = ord;
    r.node = node;
    r.strict_node = strict;
    r.target_node = 2'($urandom());
    r.page_frame = 12'($urandom());
    return r;
  endfunction

  function automatic req_t make_release(block_t b, logic [1:0] kind);
    req_t r;
    r.kind = kind;
    r.block_order = (kind == KIND_MIGRATE) ? 4'($urandom()) : b.order;
    r.node = b.zone;
    r.target_node = 2'($urandom());
    r.strict_node = 1'($urandom());
    r.page_frame = b.frame;
    return r;
  endfunction

  // Mostly well-formed traffic drawn from the pool, plus broken frees and noise.
  function automatic req_t random_request();
    req_t r;
    block_t b;
    int sel, idx;
    sel = $urandom_range(0, 99);
    if (held_blocks.size() > 120) sel = $urandom_range(40, 99);
    if (held_blocks.size() == 0 && sel >= 45 && sel < 92) sel = 0;
    if (sel < 45) begin
      r = make_alloc(pick_order(), 2'($urandom()), $urandom_range(0, 3) == 0);
    end else if (sel < 92) begin
      idx = $urandom_range(0, held_blocks.size() - 1);
      b = held_blocks[idx];
      if (sel < 80) begin
        r = make_release(b, KIND_FREE);
        held_blocks.delete(idx);
      end else if (sel < 86) begin
        r = make_release(b, KIND_MIGRATE);
        held_blocks.delete(idx);
      end else begin
        // Corrupted free: wrong order, frame or zone, usually rejected.
        r = make_release(b, KIND_FREE);
        case ($urandom_range(0, 2))
          0: r.block_order = r.block_order + 4'd1;
          1: r.page_frame = r.page_frame ^ (12'd1 << $urandom_range(0, 11));
          default: r.node = r.node + 2'd1;
        endcase
      end
    end else begin
      r = REQ_W'($urandom());
    end
    return r;
  endfunction

  task automatic random_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        send_request(random_request());
        burst--;
        left--;
      end
      // Some stretches run back to back with no gap at all.
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
    end
  endtask

  task automatic directed_part();
    req_t r;
    block_t b;
    send_request(make_alloc(0, 0, 0));
    send_request(make_alloc(10, 0, 0));
    send_request(make_alloc(11, 0, 0));
    send_request(make_alloc(15, 1, 1));
    r = make_alloc(0, 0, 0);
    r.kind = KIND_UNUSED;
    send_request(r);
    send_request(make_alloc(2, 1, 1));
    send_request(make_alloc(2, 1, 0));
    send_request(make_alloc(0, 3, 0));
    r = make_alloc(0, 0, 0);
    r.kind = KIND_FREE;
    r.page_frame = 12'd4095;
    send_request(r);
    r.page_frame = 12'd1;
    r.block_order = 4'd1;
    send_request(r);
    r.node = 2'd2;
    r.page_frame = 12'd0;
    r.block_order = 4'd0;
    send_request(r);
    r.node = 2'd1;
    r.page_frame = 12'd4;
    r.block_order = 4'd2;
    send_request(r);
    drain();
    // Legal free, then the same free again, which must be rejected.
    b = held_blocks.pop_front();
    send_request(make_release(b, KIND_FREE));
    send_request(make_release(b, KIND_FREE));
    b = held_blocks.pop_front();
    send_request(make_release(b, KIND_FREE));
    r = make_release(b, KIND_FREE);
    r.block_order = 4'd11;
    send_request(r);
    // Migrates into the three-page zone until it runs dry.
    repeat (3) begin
      drain();
      if (held_blocks.size() > 0) begin
        r = make_release(held_blocks.pop_front(), KIND_MIGRATE);
        r.target_node = 2'd1;
        send_request(r);
      end
    end
    r.node = 2'd2;
    send_request(r);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_req = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    steady_out = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    random_phase(300);
    configure(2, 4096, 3, 0, 0);
    write_register(CFG_NO_REG, 13'h1FFF);
    directed_part();
    random_phase(300);
    // Hold the sender until the block has answered everything, then resume.
    drain();
    random_phase(30);
    configure(4, 4096, 4096, 4096, 4096);
    random_phase(350);
    configure(0, 37, 0, 0, 0);
    random_phase(300);
    configure(7, 8191, 1, 0, 2048);
    random_phase(300);
    steady_out = 1;
    configure(3, 0, 1025, 4096, 5);
    random_phase(350);

    drain();
    repeat (200) @(negedge clk);
    $display("Covered resets and six zone layouts: %0d ok, %0d out of memory, %0d rejected.",
             n_ok, n_nomem, n_badarg);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
